// File: rtl/dltr_pkg.sv
// Shared types and constants for the dense layer training engine.
`default_nettype none
package dltr_pkg;
    localparam int MAX_RES     = 16;
    localparam int OFIFO_DEPTH = 32;
    localparam int TQ_DEPTH    = 4;

    localparam logic [2:0] CMD_FWD  = 3'd0;
    localparam logic [2:0] CMD_BWD  = 3'd1;
    localparam logic [2:0] CMD_UPD  = 3'd2;
    localparam logic [2:0] CMD_ZERO = 3'd3;
    localparam logic [2:0] CMD_LOAD = 3'd4;

    localparam logic [4:0]  BIAS_ROW = 5'd16;
    localparam logic [15:0] LR_RESET = 16'd655;
    localparam logic        KIND_FWD = 1'b0;
    localparam logic        KIND_BWD = 1'b1;

    typedef struct packed {
        logic [2:0]         command;
        logic [4:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] data_value;
        logic               last_element;
    } t_in_word;

    typedef struct packed {
        logic               result_kind;
        logic [3:0]         result_index;
        logic signed [15:0] result_value;
        logic               result_last;
        logic               saturated;
    } t_out_word;

    typedef enum logic [2:0] {K_FWD, K_BWD, K_UPD, K_ZERO, K_LDW, K_LDB} t_kind;

    // classified command as handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic               hit;
        logic [4:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
        logic               last;
    } t_task;
endpackage
`default_nettype wire

// File: rtl/dense_layer_train_engine.sv
// Top level of the dense layer training engine.
`default_nettype none
// Fully connected layer with forward pass, backward pass, gradient accumulation
// and clipped SGD update in signed Q8.8. Words enter through a push/full queue
// and results leave through an empty/pop queue; the learning rate sits at APB
// address 0. All work runs through one read/multiply/accumulate pipeline on
// single-port-read memories, one weight per cycle. A forward or backward element
// with its last flag set then emits its run of min(n,16) results, n being
// OUT_DIM or IN_DIM. After reset a clearing pass over all IN_DIM*OUT_DIM
// gradient entries holds full high.
module dense_layer_train_engine import dltr_pkg::*; #(
    parameter int IN_DIM  = 16,
    parameter int OUT_DIM = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_word    i_in_data,
    output logic             empty,
    input  wire logic        pop,
    output t_out_word        o_out_data
);
    localparam logic REG_LR = 1'b0;

    logic [15:0] r_lr;
    t_task       task_w;
    logic        task_vld;
    logic        task_take;
    logic        clearing;
    logic        out_room;
    logic        out_push;
    t_out_word   out_word;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LR) ? {16'd0, r_lr} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr <= LR_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_LR) begin
            r_lr <= pwdata[15:0];
        end
    end

    dltr_front #(.IN_DIM(IN_DIM), .OUT_DIM(OUT_DIM)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_word      (i_in_data),
        .i_hold      (clearing),
        .o_full      (full),
        .o_task      (task_w),
        .o_task_vld  (task_vld),
        .i_task_take (task_take)
    );

    dltr_back #(.IN_DIM(IN_DIM), .OUT_DIM(OUT_DIM)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lr        (r_lr),
        .i_task      (task_w),
        .i_task_vld  (task_vld),
        .o_task_take (task_take),
        .o_clearing  (clearing),
        .i_out_room  (out_room),
        .o_out_push  (out_push),
        .o_out_word  (out_word)
    );

    dltr_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_word  (out_word),
        .o_room  (out_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_word  (o_out_data)
    );
endmodule
`default_nettype wire

// File: rtl/dltr_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
`default_nettype none
module dltr_front import dltr_pkg::*; #(
    parameter int IN_DIM  = 16,
    parameter int OUT_DIM = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_word i_word,
    input  wire logic     i_hold,
    output logic          o_full,
    output t_task         o_task,
    output logic          o_task_vld,
    input  wire logic     i_task_take
);
    localparam int QAW = $clog2(TQ_DEPTH);

    t_task            c_task;
    logic             c_keep;
    t_task            r_q [TQ_DEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic             wr_en;
    logic             rd_en;

    always_comb begin
        c_task.kind  = K_FWD;
        c_task.hit   = 1'b0;
        c_task.row   = i_word.row_index;
        c_task.col   = i_word.col_index;
        c_task.value = i_word.data_value;
        c_task.last  = i_word.last_element;
        c_keep       = 1'b0;
        case (i_word.command)
            CMD_FWD: begin
                c_task.kind = K_FWD;
                c_task.hit  = 32'(i_word.row_index) < IN_DIM;
                c_keep      = 1'b1;
            end
            CMD_BWD: begin
                c_task.kind = K_BWD;
                c_task.hit  = 32'(i_word.col_index) < OUT_DIM;
                c_keep      = 1'b1;
            end
            CMD_UPD: begin
                c_task.kind = K_UPD;
                c_keep      = 1'b1;
            end
            CMD_ZERO: begin
                c_task.kind = K_ZERO;
                c_keep      = 1'b1;
            end
            CMD_LOAD: begin
                // loads to addresses outside the arrays are dropped here
                if (32'(i_word.col_index) < OUT_DIM) begin
                    if (i_word.row_index == BIAS_ROW) begin
                        c_task.kind = K_LDB;
                        c_task.hit  = 1'b1;
                        c_keep      = 1'b1;
                    end else if (32'(i_word.row_index) < IN_DIM) begin
                        c_task.kind = K_LDW;
                        c_task.hit  = 1'b1;
                        c_keep      = 1'b1;
                    end
                end
            end
            default: c_keep = 1'b0;
        endcase
    end

    assign o_full     = (r_cnt == (QAW+1)'(TQ_DEPTH)) || i_hold;
    assign o_task_vld = r_cnt != '0;
    assign o_task     = r_q[r_rp];
    assign wr_en      = i_push && !o_full && c_keep;
    assign rd_en      = i_task_take && o_task_vld;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= c_task;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/dltr_back.sv
// Back end: parameter memories and the shared read / multiply / accumulate pipeline.
`default_nettype none
module dltr_back import dltr_pkg::*; #(
    parameter int IN_DIM  = 16,
    parameter int OUT_DIM = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_lr,
    input  wire t_task       i_task,
    input  wire logic        i_task_vld,
    output logic             o_task_take,
    output logic             o_clearing,
    input  wire logic        i_out_room,
    output logic             o_out_push,
    output t_out_word        o_out_word
);
    localparam int NW    = IN_DIM * OUT_DIM;
    localparam int ACC_D = (IN_DIM > OUT_DIM) ? IN_DIM : OUT_DIM;
    localparam int WAW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int LAW   = (ACC_D > 1) ? $clog2(ACC_D) : 1;
    localparam int OAW   = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int IAW   = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int CW    = $clog2(NW + 1);
    localparam int N_FWD = (OUT_DIM < MAX_RES) ? OUT_DIM : MAX_RES;
    localparam int N_BWD = (IN_DIM < MAX_RES) ? IN_DIM : MAX_RES;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FWD, ST_BWD, ST_BGR, ST_UPW, ST_UPB,
        ST_ZERO, ST_DRAIN, ST_EWAIT, ST_EMIT
    } t_state;
    typedef enum logic [2:0] {
        OP_NONE, OP_FWD, OP_BWD, OP_BGR, OP_UPW, OP_UPB, OP_EMIT
    } t_op;
    typedef enum logic [1:0] {MD_IDLE, MD_FWD, MD_BWD} t_mode;

    // memories
    logic [15:0] mem_w   [NW];
    logic [23:0] mem_wg  [NW];
    logic [15:0] mem_b   [OUT_DIM];
    logic [23:0] mem_bg  [OUT_DIM];
    logic [15:0] mem_x   [IN_DIM];
    logic [31:0] mem_acc [ACC_D];
    logic [15:0] r_w_rd;
    logic [23:0] r_wg_rd;
    logic [15:0] r_b_rd;
    logic [23:0] r_bg_rd;
    logic [15:0] r_x_rd;
    logic [31:0] r_acc_rd;

    // control
    t_state           r_state;
    t_mode            r_mode;
    logic [CW-1:0]    r_cnt;
    logic [WAW-1:0]   r_waddr;
    t_task            r_item;
    logic             r_emit;
    logic             r_close;
    logic [ACC_D-1:0] r_lane_vld;
    logic [ACC_D-1:0] r_lane_sat;
    logic             take;
    logic             clr;
    logic [CW-1:0]    emit_last_idx;

    // issue stage
    t_op              s0_op;
    logic [WAW-1:0]   s0_addr;
    logic [LAW-1:0]   s0_lane;
    logic             s0_last;
    logic [WAW-1:0]   w_ra;
    logic [IAW-1:0]   x_ra;
    logic [LAW-1:0]   acc_ra;
    logic [OAW-1:0]   b_ra;
    logic [OAW-1:0]   bg_ra;

    // stage 1 / stage 2 registers
    t_op              r_s1_op;
    logic [WAW-1:0]   r_s1_addr;
    logic [LAW-1:0]   r_s1_lane;
    logic             r_s1_last;
    t_op              r_s2_op;
    logic [WAW-1:0]   r_s2_addr;
    logic [LAW-1:0]   r_s2_lane;
    logic signed [31:0] r_s2_acc;
    logic signed [31:0] r_s2_p;
    logic signed [31:0] r_s2_px;
    logic signed [23:0] r_s2_g;
    logic signed [15:0] r_s2_w;
    t_out_word        r_s2_res;

    // stage 1 logic
    logic signed [31:0] acc_cur;
    logic signed [33:0] em_sum;
    logic signed [25:0] em_sh;
    logic               em_ovf;
    logic signed [15:0] em_val;
    logic signed [23:0] g_sel;
    logic signed [9:0]  g_clip;
    logic signed [26:0] upd_p;
    logic signed [31:0] p_w;
    logic signed [31:0] p_x;
    t_out_word          s1_res;

    // stage 2 logic
    logic signed [32:0] acc_sum;
    logic               acc_ovf;
    logic signed [31:0] acc_new;
    logic signed [32:0] gr_sum;
    logic signed [24:0] gr_d;
    logic signed [25:0] wg_sum;
    logic signed [23:0] wg_new;
    logic signed [24:0] bg_sum;
    logic signed [23:0] bg_new;
    logic signed [27:0] up_t;
    logic signed [11:0] up_d;
    logic signed [16:0] up_sub;
    logic signed [15:0] up_new;

    // write ports
    logic             w_we,   b_we,   wg_we,  bg_we,  x_we,  acc_we;
    logic [WAW-1:0]   w_wa,   wg_wa;
    logic [OAW-1:0]   b_wa,   bg_wa;
    logic [IAW-1:0]   x_wa;
    logic [15:0]      w_wd,   b_wd,   x_wd;
    logic [23:0]      wg_wd,  bg_wd;

    assign take          = (r_state == ST_IDLE) && i_task_vld;
    assign o_task_take   = take;
    assign clr           = (r_state == ST_CLEAR) || (r_state == ST_ZERO);
    assign o_clearing    = r_state == ST_CLEAR;
    assign emit_last_idx = (r_mode == MD_BWD) ? CW'(N_BWD - 1) : CW'(N_FWD - 1);

    always_comb begin
        s0_op   = OP_NONE;
        s0_addr = '0;
        s0_lane = r_cnt[LAW-1:0];
        s0_last = 1'b0;
        w_ra    = r_waddr;
        x_ra    = r_cnt[IAW-1:0];
        acc_ra  = r_cnt[LAW-1:0];
        b_ra    = r_cnt[OAW-1:0];
        bg_ra   = r_cnt[OAW-1:0];
        case (r_state)
            ST_FWD: s0_op = OP_FWD;
            ST_BWD: begin
                s0_op   = OP_BWD;
                s0_addr = r_waddr;
            end
            ST_BGR: begin
                s0_op   = OP_BGR;
                bg_ra   = OAW'(r_item.col);
                s0_addr = WAW'(r_item.col);
            end
            ST_UPW: begin
                s0_op   = OP_UPW;
                w_ra    = r_cnt[WAW-1:0];
                s0_addr = r_cnt[WAW-1:0];
            end
            ST_UPB: begin
                s0_op   = OP_UPB;
                s0_addr = r_cnt[WAW-1:0];
            end
            ST_EMIT: begin
                s0_op   = OP_EMIT;
                s0_last = r_cnt == emit_last_idx;
            end
            default: s0_op = OP_NONE;
        endcase
    end

    // stage 1: read data is here; multiply and form results
    always_comb begin
        acc_cur = r_lane_vld[r_s1_lane] ? $signed(r_acc_rd) : 32'sd0;
        em_sum  = 34'(acc_cur) + 34'sd128
                + ((r_mode == MD_FWD) ? 34'($signed({r_b_rd, 8'h00})) : 34'sd0);
        em_sh   = em_sum[33:8];
        em_ovf  = !((&em_sh[25:15]) || !(|em_sh[25:15]));
        em_val  = em_ovf ? (em_sh[25] ? 16'sh8000 : 16'sh7fff) : em_sh[15:0];
        g_sel   = ((r_s1_op == OP_UPB) || (r_s1_op == OP_BGR))
                ? $signed(r_bg_rd) : $signed(r_wg_rd);
        if (g_sel > 24'sd256) begin
            g_clip = 10'sd256;
        end else if (g_sel < -24'sd256) begin
            g_clip = -10'sd256;
        end else begin
            g_clip = g_sel[9:0];
        end
        upd_p   = $signed({1'b0, i_lr}) * g_clip;
        p_w     = r_item.value * $signed(r_w_rd);
        p_x     = r_item.value * $signed(r_x_rd);
        s1_res.result_kind  = (r_mode == MD_BWD) ? KIND_BWD : KIND_FWD;
        s1_res.result_index = 4'(r_s1_lane);
        s1_res.result_value = em_val;
        s1_res.result_last  = r_s1_last;
        s1_res.saturated    = em_ovf || r_lane_sat[r_s1_lane];
    end

    // stage 2: saturating adds and write back
    always_comb begin
        acc_sum = 33'(r_s2_acc) + 33'(r_s2_p);
        acc_ovf = acc_sum[32] != acc_sum[31];
        acc_new = acc_ovf ? (acc_sum[32] ? 32'sh80000000 : 32'sh7fffffff) : acc_sum[31:0];
        gr_sum  = 33'(r_s2_px) + 33'sd128;
        gr_d    = gr_sum[32:8];
        wg_sum  = 26'(r_s2_g) + 26'(gr_d);
        wg_new  = (wg_sum[25:23] == 3'b000 || wg_sum[25:23] == 3'b111) ? wg_sum[23:0]
                : (wg_sum[25] ? 24'sh800000 : 24'sh7fffff);
        bg_sum  = 25'(r_s2_g) + 25'(r_item.value);
        bg_new  = (bg_sum[24] == bg_sum[23]) ? bg_sum[23:0]
                : (bg_sum[24] ? 24'sh800000 : 24'sh7fffff);
        up_t    = 28'($signed(r_s2_p[26:0])) + 28'sd32768;
        up_d    = up_t[27:16];
        up_sub  = 17'(r_s2_w) - 17'(up_d);
        up_new  = (up_sub[16] == up_sub[15]) ? up_sub[15:0]
                : (up_sub[16] ? 16'sh8000 : 16'sh7fff);
    end

    always_comb begin
        w_we   = (take && i_task.kind == K_LDW && i_task.hit) || (r_s2_op == OP_UPW);
        w_wa   = (r_s2_op == OP_UPW) ? r_s2_addr
               : WAW'(32'(i_task.row) * OUT_DIM + 32'(i_task.col));
        w_wd   = (r_s2_op == OP_UPW) ? up_new : i_task.value;
        b_we   = (take && i_task.kind == K_LDB && i_task.hit) || (r_s2_op == OP_UPB);
        b_wa   = (r_s2_op == OP_UPB) ? r_s2_addr[OAW-1:0] : OAW'(i_task.col);
        b_wd   = (r_s2_op == OP_UPB) ? up_new : i_task.value;
        wg_we  = clr || (r_s2_op == OP_BWD);
        wg_wa  = clr ? r_cnt[WAW-1:0] : r_s2_addr;
        wg_wd  = clr ? 24'd0 : wg_new;
        bg_we  = (clr && 32'(r_cnt) < OUT_DIM) || (r_s2_op == OP_BGR);
        bg_wa  = clr ? r_cnt[OAW-1:0] : r_s2_addr[OAW-1:0];
        bg_wd  = clr ? 24'd0 : bg_new;
        x_we   = take && i_task.kind == K_FWD && i_task.hit;
        x_wa   = IAW'(i_task.row);
        x_wd   = i_task.value;
        acc_we = (r_s2_op == OP_FWD) || (r_s2_op == OP_BWD);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_w[w_wa] <= w_wd;
        end
        r_w_rd <= mem_w[w_ra];
        if (wg_we) begin
            mem_wg[wg_wa] <= wg_wd;
        end
        r_wg_rd <= mem_wg[w_ra];
        if (b_we) begin
            mem_b[b_wa] <= b_wd;
        end
        r_b_rd <= mem_b[b_ra];
        if (bg_we) begin
            mem_bg[bg_wa] <= bg_wd;
        end
        r_bg_rd <= mem_bg[bg_ra];
        if (x_we) begin
            mem_x[x_wa] <= x_wd;
        end
        r_x_rd <= mem_x[x_ra];
        if (acc_we) begin
            mem_acc[r_s2_lane] <= acc_new;
        end
        r_acc_rd <= mem_acc[acc_ra];
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_addr <= s0_addr;
        r_s1_lane <= s0_lane;
        r_s1_last <= s0_last;
        r_s2_addr <= r_s1_addr;
        r_s2_lane <= r_s1_lane;
        r_s2_acc  <= acc_cur;
        r_s2_p    <= ((r_s1_op == OP_UPW) || (r_s1_op == OP_UPB)) ? 32'(upd_p) : p_w;
        r_s2_px   <= p_x;
        r_s2_g    <= g_sel;
        r_s2_w    <= (r_s1_op == OP_UPB) ? $signed(r_b_rd) : $signed(r_w_rd);
        r_s2_res  <= s1_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_mode     <= MD_IDLE;
            r_cnt      <= '0;
            r_emit     <= 1'b0;
            r_close    <= 1'b0;
            r_lane_vld <= '0;
            r_lane_sat <= '0;
            r_s1_op    <= OP_NONE;
            r_s2_op    <= OP_NONE;
        end else begin
            r_s1_op <= s0_op;
            r_s2_op <= r_s1_op;
            case (r_state)
                ST_CLEAR, ST_ZERO: begin
                    if (r_cnt == CW'(NW - 1)) begin
                        r_state <= ST_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_task_vld) begin
                        r_item <= i_task;
                        r_cnt  <= '0;
                        case (i_task.kind)
                            K_FWD: begin
                                // a run of the other kind is dropped
                                if (r_mode != MD_FWD) begin
                                    r_lane_vld <= '0;
                                    r_lane_sat <= '0;
                                end
                                r_mode  <= MD_FWD;
                                r_emit  <= i_task.last;
                                r_waddr <= WAW'(32'(i_task.row) * OUT_DIM);
                                r_state <= i_task.hit ? ST_FWD : ST_DRAIN;
                            end
                            K_BWD: begin
                                if (r_mode != MD_BWD) begin
                                    r_lane_vld <= '0;
                                    r_lane_sat <= '0;
                                end
                                r_mode  <= MD_BWD;
                                r_emit  <= i_task.last;
                                r_waddr <= WAW'(i_task.col);
                                r_state <= i_task.hit ? ST_BWD : ST_DRAIN;
                            end
                            K_UPD: begin
                                r_emit  <= 1'b0;
                                r_state <= ST_UPW;
                            end
                            K_ZERO:  r_state <= ST_ZERO;
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_FWD: begin
                    r_waddr <= r_waddr + 1'b1;
                    if (r_cnt == CW'(OUT_DIM - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_BWD: begin
                    r_waddr <= r_waddr + WAW'(OUT_DIM);
                    if (r_cnt == CW'(IN_DIM - 1)) begin
                        r_state <= ST_BGR;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_BGR: r_state <= ST_DRAIN;
                ST_UPW: begin
                    if (r_cnt == CW'(NW - 1)) begin
                        r_state <= ST_UPB;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_UPB: begin
                    if (r_cnt == CW'(OUT_DIM - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (r_s1_op == OP_NONE && r_s2_op == OP_NONE) begin
                        if (r_close) begin
                            r_close    <= 1'b0;
                            r_mode     <= MD_IDLE;
                            r_lane_vld <= '0;
                            r_lane_sat <= '0;
                            r_state    <= ST_IDLE;
                        end else if (r_emit) begin
                            r_emit  <= 1'b0;
                            r_cnt   <= '0;
                            r_state <= ST_EWAIT;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_EWAIT: begin
                    if (i_out_room) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_cnt == emit_last_idx) begin
                        r_close <= 1'b1;
                        r_state <= ST_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            if (acc_we) begin
                r_lane_vld[r_s2_lane] <= 1'b1;
                if (acc_ovf) begin
                    r_lane_sat[r_s2_lane] <= 1'b1;
                end
            end
        end
    end

    assign o_out_push = r_s2_op == OP_EMIT;
    assign o_out_word = r_s2_res;

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_s1_op == OP_NONE && r_s2_op == OP_NONE))
        else $error("pipeline not empty in idle");

    a_no_run_no_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_mode == MD_IDLE) |-> (r_lane_vld == '0))
        else $error("accumulator lanes live without an open run");

    a_emit_has_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_mode != MD_IDLE))
        else $error("emit without an open run");
endmodule
`default_nettype wire

// File: rtl/dltr_ofifo.sv
// Result queue between the back end and the output port.
`default_nettype none
module dltr_ofifo import dltr_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_word,
    output logic           o_room,
    output logic           o_empty,
    input  wire logic      i_pop,
    output t_out_word      o_word
);
    localparam int AW = $clog2(OFIFO_DEPTH);

    t_out_word      r_q [OFIFO_DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           rd_en;

    assign o_empty = r_cnt == '0;
    // room for a whole run of results
    assign o_room  = r_cnt <= (AW+1)'(OFIFO_DEPTH - MAX_RES);
    assign o_word  = r_q[r_rp];
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_word;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire
